// ----- rtl/deq_pkg.sv -----
`default_nettype none

package deq_pkg;

  // Default ring depth
  localparam int unsigned DefDepth = 16;

  // Field widths
  localparam int unsigned WordW  = 32;
  localparam int unsigned ReqW   = 2;
  localparam int unsigned StatW  = 2;
  localparam int unsigned FillW  = 5;

  // Request codes
  localparam logic [ReqW-1:0] REQ_PUSH_FRONT = 2'd0;
  localparam logic [ReqW-1:0] REQ_PUSH_BACK  = 2'd1;
  localparam logic [ReqW-1:0] REQ_POP_FRONT  = 2'd2;
  localparam logic [ReqW-1:0] REQ_POP_BACK   = 2'd3;

  // Status codes
  localparam logic [StatW-1:0] ST_DONE  = 2'd0;
  localparam logic [StatW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatW-1:0] ST_FULL  = 2'd2;

  // Request payload
  typedef struct packed {
    logic [ReqW-1:0]         req_type;
    logic signed [WordW-1:0] push_value;
  } deq_req_t;

  // Response payload
  typedef struct packed {
    logic signed [WordW-1:0] pop_value;
    logic [StatW-1:0]        status;
    logic [FillW-1:0]        fill_count;
  } deq_rsp_t;

  // Operation broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CellHold,
    CellShiftIn,
    CellShiftOut,
    CellAppend,
    CellDropTail
  } cell_op_e;

endpackage

`default_nettype wire

// ----- rtl/deq_cell.sv -----
`default_nettype none

// One slot of the chain. Entries are packed from cell 0 (front) upward.
module deq_cell (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire deq_pkg::cell_op_e              op_i,
  input  wire logic signed [deq_pkg::WordW-1:0] new_data_i,
  input  wire logic signed [deq_pkg::WordW-1:0] left_data_i,
  input  wire logic                           left_valid_i,
  input  wire logic signed [deq_pkg::WordW-1:0] right_data_i,
  input  wire logic                           right_valid_i,
  input  wire logic signed [deq_pkg::WordW-1:0] right_carry_i,
  output logic signed [deq_pkg::WordW-1:0]    data_o,
  output logic                                valid_o,
  output logic signed [deq_pkg::WordW-1:0]    carry_o
);
  import deq_pkg::*;

  logic signed [WordW-1:0] data_q, data_d;
  logic signed [WordW-1:0] carry_q;
  logic                    valid_q, valid_d;
  logic                    tail;

  // This cell holds the last entry
  assign tail = valid_q & ~right_valid_i;

  // Next slot contents
  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    case (op_i)
      CellShiftIn: begin
        data_d  = left_data_i;
        valid_d = left_valid_i;
      end
      CellShiftOut: begin
        data_d  = right_data_i;
        valid_d = right_valid_i;
      end
      CellAppend: begin
        // first empty slot takes the new word
        if (!valid_q && left_valid_i) begin
          data_d  = new_data_i;
          valid_d = 1'b1;
        end
      end
      CellDropTail: begin
        if (tail) begin
          valid_d = 1'b0;
        end
      end
      CellHold: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload and tail carry: the tail word moves one cell toward the front per cycle
  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    carry_q <= tail ? data_q : right_carry_i;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;
  assign carry_o = carry_q;

endmodule

`default_nettype wire

// ----- rtl/double_ended_queue.sv -----
`default_nettype none

// Channel   | Signals                 | Handshake
// ----------+-------------------------+-------------------------------------
// request   | start, req_i            | taken when start is high, busy low
// response  | rsp_valid_o, rsp_o      | one-cycle strobe, cannot be stalled
//
// Push front, push back, pop front and refused requests: the response strobes
// in the cycle after the request is taken, and the next request may be taken in
// that same cycle. A pop back holds busy high while the tail word walks down the
// cell chain one cell per cycle; busy drops in the same cycle that its response
// strobes. rst_ni clears all valid bits, the count and the response register;
// the response side never stalls.
module double_ended_queue #(
  parameter int unsigned Depth = deq_pkg::DefDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire deq_pkg::deq_req_t req_i,
  output logic                   busy,
  output logic                   rsp_valid_o,
  output deq_pkg::deq_rsp_t      rsp_o
);
  import deq_pkg::*;

  localparam int unsigned CntW = $clog2(Depth + 1);

  typedef enum logic {
    StIdle,
    StTailWait
  } state_e;

  state_e               state_q;
  logic [CntW-1:0]      count_q;
  logic [CntW-1:0]      wait_q;
  logic                 rsp_valid_q;
  deq_rsp_t             rsp_q;

  logic signed [WordW-1:0] data_w  [Depth];
  logic signed [WordW-1:0] carry_w [Depth];
  logic [Depth-1:0]        valid_w;

  cell_op_e cell_op;
  logic     accept, full, empty, is_push, tail_done;

  assign accept    = start && (state_q == StIdle);
  assign full      = valid_w[Depth-1];
  assign empty     = !valid_w[0];
  assign is_push   = (req_i.req_type == REQ_PUSH_FRONT) || (req_i.req_type == REQ_PUSH_BACK);
  assign tail_done = (state_q == StTailWait) && (wait_q == '0);

  // Chain operation for this cycle
  always_comb begin
    cell_op = CellHold;
    if (accept) begin
      case (req_i.req_type)
        REQ_PUSH_FRONT: if (!full)  cell_op = CellShiftIn;
        REQ_PUSH_BACK:  if (!full)  cell_op = CellAppend;
        REQ_POP_FRONT:  if (!empty) cell_op = CellShiftOut;
        REQ_POP_BACK:   cell_op = CellHold;
        default:        cell_op = CellHold;
      endcase
    end else if (tail_done) begin
      cell_op = CellDropTail;
    end
  end

  // Cell chain
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic signed [WordW-1:0] left_data, right_data, right_carry;
    logic                    left_valid, right_valid;

    if (i == 0) begin : g_first
      assign left_data  = req_i.push_value;
      assign left_valid = 1'b1;
    end else begin : g_mid
      assign left_data  = data_w[i-1];
      assign left_valid = valid_w[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign right_data  = '0;
      assign right_valid = 1'b0;
      assign right_carry = '0;
    end else begin : g_inner
      assign right_data  = data_w[i+1];
      assign right_valid = valid_w[i+1];
      assign right_carry = carry_w[i+1];
    end

    deq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .op_i          (cell_op),
      .new_data_i    (req_i.push_value),
      .left_data_i   (left_data),
      .left_valid_i  (left_valid),
      .right_data_i  (right_data),
      .right_valid_i (right_valid),
      .right_carry_i (right_carry),
      .data_o        (data_w[i]),
      .valid_o       (valid_w[i]),
      .carry_o       (carry_w[i])
    );
  end

  // Sequencer, count and response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      wait_q      <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      rsp_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept) begin
            if (is_push) begin
              rsp_valid_q      <= 1'b1;
              rsp_q.pop_value  <= '0;
              if (full) begin
                rsp_q.status     <= ST_FULL;
                rsp_q.fill_count <= FillW'(count_q);
              end else begin
                rsp_q.status     <= ST_DONE;
                rsp_q.fill_count <= FillW'(count_q + 1'b1);
                count_q          <= count_q + 1'b1;
              end
            end else if (empty) begin
              rsp_valid_q      <= 1'b1;
              rsp_q.pop_value  <= '0;
              rsp_q.status     <= ST_EMPTY;
              rsp_q.fill_count <= FillW'(count_q);
            end else if (req_i.req_type == REQ_POP_FRONT) begin
              rsp_valid_q      <= 1'b1;
              rsp_q.pop_value  <= data_w[0];
              rsp_q.status     <= ST_DONE;
              rsp_q.fill_count <= FillW'(count_q - 1'b1);
              count_q          <= count_q - 1'b1;
            end else begin
              // pop back: wait for the tail word to reach cell 0
              state_q <= StTailWait;
              wait_q  <= count_q - 1'b1;
            end
          end
        end
        StTailWait: begin
          if (wait_q == '0) begin
            state_q          <= StIdle;
            rsp_valid_q      <= 1'b1;
            rsp_q.pop_value  <= carry_w[0];
            rsp_q.status     <= ST_DONE;
            rsp_q.fill_count <= FillW'(count_q - 1'b1);
            count_q          <= count_q - 1'b1;
          end else begin
            wait_q <= wait_q - 1'b1;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy        = (state_q == StTailWait);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

`ifndef SYNTHESIS
  // Count agrees with the occupied cells
  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CntW'($countones(valid_w)) == count_q)
    else $error("entry count differs from occupied cells");

  // Tail wait only runs on a non-empty chain
  a_wait_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StTailWait) |-> valid_w[0])
    else $error("tail wait with empty chain");

  // Requests other than pop back answer in the next cycle
  a_quick_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.req_type != REQ_POP_BACK)) |=> rsp_valid_o)
    else $error("missing response after single-cycle request");

  // No response without a request or a finished tail wait
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!accept && !tail_done) |=> !rsp_valid_o)
    else $error("response without request");
`endif

endmodule

`default_nettype wire

// ----- tb/deq_checker.sv -----
`timescale 1ns / 1ps

// Watches the request and response channels of the deque, predicts each
// response from its own copy of the ring and compares field by field.
module deq_checker
  import deq_pkg::*;
#(
  parameter int unsigned Depth = DefDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     busy_i,
  input  deq_req_t req_i,
  input  logic     rsp_valid_i,
  input  deq_rsp_t rsp_i,
  output int       fail_cnt_o,
  output int       pending_o,
  output int       checked_o,
  output int       full_seen_o,
  output int       empty_seen_o
);

  localparam int unsigned IdxW       = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW       = $clog2(Depth + 1);
  localparam int          MaxReports = 30;

  // Predicted deque state
  logic signed [WordW-1:0] ring_q [Depth];
  logic [IdxW-1:0]         head_q;
  logic [CntW-1:0]         level_q;

  // Responses owed by the block, oldest first
  deq_rsp_t owed_rsp [$];

  int n_fail, n_pending, n_checked, n_full, n_empty;

  // Apply one request to the predicted ring and return the response it owes
  function automatic deq_rsp_t apply_request(input deq_req_t r);
    deq_rsp_t    rsp;
    int unsigned slot;
    rsp        = '0;
    rsp.status = ST_DONE;
    case (r.req_type)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (level_q == CntW'(Depth)) begin
          rsp.status = ST_FULL;
        end else begin
          if (r.req_type == REQ_PUSH_FRONT) begin
            head_q = (head_q == '0) ? IdxW'(Depth - 1) : head_q - 1'b1;
            slot   = head_q;
          end else begin
            slot = (int'(head_q) + int'(level_q)) % Depth;
          end
          ring_q[slot] = r.push_value;
          level_q      = level_q + 1'b1;
        end
      end
      default: begin
        if (level_q == '0) begin
          rsp.status = ST_EMPTY;
        end else begin
          if (r.req_type == REQ_POP_FRONT) begin
            rsp.pop_value = ring_q[head_q];
            head_q        = (int'(head_q) + 1 == Depth) ? '0 : head_q + 1'b1;
          end else begin
            slot          = (int'(head_q) + int'(level_q) - 1) % Depth;
            rsp.pop_value = ring_q[slot];
          end
          level_q = level_q - 1'b1;
        end
      end
    endcase
    rsp.fill_count = FillW'(level_q);
    return rsp;
  endfunction

  // Report a single field mismatch; output is capped to keep the log short
  function automatic bit field_ok(input string tag, input logic signed [WordW-1:0] want,
                                  input logic signed [WordW-1:0] got);
    if (got === want) return 1'b1;
    if (n_fail < MaxReports) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, tag, want, got);
    end
    return 1'b0;
  endfunction

  // Sample both channels at each edge: requests first, then the response
  always @(posedge clk_i or negedge rst_ni) begin
    deq_rsp_t want;
    if (!rst_ni) begin
      head_q    = '0;
      level_q   = '0;
      owed_rsp.delete();
      n_fail    = 0;
      n_pending = 0;
      n_checked = 0;
      n_full    = 0;
      n_empty   = 0;
    end else begin
      if (start_i && !busy_i) begin
        want = apply_request(req_i);
        if (want.status == ST_FULL) n_full++;
        if (want.status == ST_EMPTY) n_empty++;
        owed_rsp.push_back(want);
        n_pending++;
      end
      if (rsp_valid_i) begin
        if (owed_rsp.size() == 0) begin
          if (n_fail < MaxReports) begin
            $display("%0t: response with none outstanding, actual %0d/%0d/%0d", $time,
                     rsp_i.pop_value, rsp_i.status, rsp_i.fill_count);
          end
          n_fail++;
        end else begin
          want = owed_rsp.pop_front();
          n_pending--;
          n_checked++;
          if (!field_ok("pop_value", want.pop_value, rsp_i.pop_value)) n_fail++;
          if (!field_ok("status", WordW'(want.status), WordW'(rsp_i.status))) n_fail++;
          if (!field_ok("fill_count", WordW'(want.fill_count), WordW'(rsp_i.fill_count)))
            n_fail++;
        end
      end
    end
    fail_cnt_o   <= n_fail;
    pending_o    <= n_pending;
    checked_o    <= n_checked;
    full_seen_o  <= n_full;
    empty_seen_o <= n_empty;
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

// Drives requests into the deque through directed and random phases; the
// checker beside the block predicts and compares every response.
module tb;
  import deq_pkg::*;

  localparam int unsigned Depth      = DefDepth;
  localparam int unsigned RandItems  = 800;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned IdlePct [4] = '{0, 59, 8, 59};

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  deq_req_t req    = '0;
  logic     busy;
  logic     rsp_valid;
  deq_rsp_t rsp;

  int          fail_cnt, pending, checked, full_seen, empty_seen;
  int unsigned cycle_cnt = 0;
  int unsigned sent      = 0;
  int unsigned directed  = 0;

  double_ended_queue #(
    .Depth(Depth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_i      (req),
    .busy       (busy),
    .rsp_valid_o(rsp_valid),
    .rsp_o      (rsp)
  );

  deq_checker #(
    .Depth(Depth)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .req_i       (req),
    .rsp_valid_i (rsp_valid),
    .rsp_i       (rsp),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending),
    .checked_o   (checked),
    .full_seen_o (full_seen),
    .empty_seen_o(empty_seen)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d responses outstanding", cycle_cnt, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic deq_req_t pack_req(input logic [ReqW-1:0] kind,
                                        input logic [WordW-1:0] word);
    deq_req_t r;
    r.req_type   = kind;
    r.push_value = word;
    return r;
  endfunction

  // Random request; push_pct biases toward filling or draining the ring
  function automatic deq_req_t make_req(input int unsigned push_pct);
    logic [ReqW-1:0]  kind;
    logic [WordW-1:0] word;
    if ($urandom_range(99) < push_pct) begin
      kind = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
    end else begin
      kind = $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
    end
    case ($urandom_range(15))
      0:       word = 32'h7FFF_FFFF;
      1:       word = 32'h8000_0000;
      2:       word = '0;
      3:       word = '1;
      default: word = $urandom;
    endcase
    return pack_req(kind, word);
  endfunction

  // Hold one request until the block takes it
  task automatic issue(input deq_req_t r);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk_i); while (busy);
    sent++;
  endtask

  task automatic hold_off(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Stop sending until every owed response has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    int unsigned burst_left;
    int unsigned push_pct;
    logic [WordW-1:0] word;

    burst_left = 0;
    push_pct   = 50;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: pops on an empty ring, fill to full with edge values,
    // refused pushes at both ends, then pops and pushes around the wrap
    issue(pack_req(REQ_POP_FRONT, 32'h1234_5678));
    issue(pack_req(REQ_POP_BACK, 32'h8765_4321));
    for (int i = 0; i < Depth; i++) begin
      case (i)
        0:       word = 32'h7FFF_FFFF;
        1:       word = 32'h8000_0000;
        2:       word = '0;
        3:       word = '1;
        4:       word = 32'h5555_5555;
        5:       word = 32'hAAAA_AAAA;
        default: word = $urandom;
      endcase
      issue(pack_req((i % 2) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, word));
    end
    issue(pack_req(REQ_PUSH_FRONT, 32'hDEAD_BEEF));
    issue(pack_req(REQ_PUSH_BACK, 32'hCAFE_F00D));
    issue(pack_req(REQ_POP_FRONT, '0));
    issue(pack_req(REQ_POP_BACK, '0));
    issue(pack_req(REQ_PUSH_BACK, 32'h0000_0001));
    issue(pack_req(REQ_PUSH_FRONT, 32'hFFFF_FFFE));
    directed = sent;
    drain();

    // Random phases with bursts that lean toward full, toward empty or neither
    for (int ph = 0; ph < 4; ph++) begin
      for (int k = 0; k < RandItems / 4; k++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(40, 8);
          case ($urandom_range(2))
            0:       push_pct = 85;
            1:       push_pct = 15;
            default: push_pct = 50;
          endcase
        end
        burst_left--;
        if ($urandom_range(99) < IdlePct[ph]) hold_off($urandom_range(6, 1));
        issue(make_req(push_pct));
      end
      drain();
    end

    // Let any stray response show up
    repeat (2 * Depth + 8) @(posedge clk_i);

    $display("Ran %0d requests (%0d directed) and checked %0d responses;", sent, directed,
             checked);
    $display("%0d pushes met a full ring and %0d pops an empty one.", full_seen, empty_seen);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
